// File: src/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg: shared definitions for the serial frame parser
// Parse phases, status codes, framing bytes and the result bundle that the
// parser hands to the top level.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Largest payload length that a frame may announce.
  localparam int unsigned MAX_PAYLOAD = 16;
  // Payload bytes that are kept for publication.
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CNT_W       = 32;

  localparam logic [7:0] HDR_A     = 8'h55;
  localparam logic [7:0] HDR_B     = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h0D;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CKSM  = 3'd5,
    PH_TAIL  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_OK        = 2'd1,
    ST_CKSUM_ERR = 2'd2,
    ST_TAIL_ERR  = 2'd3
  } status_t;

  // Status is the outcome of the byte being stepped; the other fields are
  // the parser registers, which always hold the values after the last step.
  typedef struct packed {
    status_t           status;
    logic [7:0]        frame_cmd;
    logic [31:0]       pitch_word;
    logic [31:0]       yaw_word;
    logic [CNT_W-1:0]  checksum_error_count;
    logic [CNT_W-1:0]  tail_error_count;
  } sfp_result_t;

endpackage

// File: src/sfp_parser.sv
// ----------------------------------------------------------------------------
// sfp_parser: frame hunter, running checksum and payload store
// Holds the parse state and advances it by one received byte whenever the
// step input is high.
// ----------------------------------------------------------------------------
module sfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output sfp_pkg::sfp_result_t result
);
  import sfp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  idx_inc;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        store_r   [STORE_DEPTH];
  logic [7:0]        store_nxt [STORE_DEPTH];
  logic [31:0]       pitch_r, pitch_nxt;
  logic [31:0]       yaw_r, yaw_nxt;
  logic [CNT_W-1:0]  cks_cnt_r, cks_cnt_nxt;
  logic [CNT_W-1:0]  tail_cnt_r, tail_cnt_nxt;
  status_t           status_nxt;

  assign idx_inc = idx_r + IDX_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    store_nxt    = store_r;
    pitch_nxt    = pitch_r;
    yaw_nxt      = yaw_r;
    cks_cnt_nxt  = cks_cnt_r;
    tail_cnt_nxt = tail_cnt_r;
    status_nxt   = ST_IDLE;
    unique case (phase_r)
      PH_HEAD2: begin
        if (rx_byte == HDR_B) begin
          phase_nxt = PH_CMD;
        end else if (rx_byte != HDR_A) begin
          phase_nxt = PH_HEAD1;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        idx_nxt = '0;
        if (rx_byte > 8'(MAX_PAYLOAD)) begin
          phase_nxt = PH_HEAD1;
        end else begin
          len_nxt   = rx_byte[IDX_W-1:0];
          sum_nxt   = cmd_r + rx_byte;
          phase_nxt = (rx_byte != 8'd0) ? PH_DATA : PH_CKSM;
        end
      end
      PH_DATA: begin
        if (idx_r < IDX_W'(STORE_DEPTH)) begin
          store_nxt[idx_r[STORE_IDX_W-1:0]] = rx_byte;
        end
        sum_nxt = sum_r + rx_byte;
        idx_nxt = idx_inc;
        if (idx_inc >= len_r) begin
          phase_nxt = PH_CKSM;
        end
      end
      PH_CKSM: begin
        if (sum_r == rx_byte) begin
          phase_nxt = PH_TAIL;
        end else begin
          cks_cnt_nxt = cks_cnt_r + CNT_W'(1);
          status_nxt  = ST_CKSUM_ERR;
          phase_nxt   = PH_HEAD1;
        end
      end
      PH_TAIL: begin
        if (rx_byte == TAIL_BYTE) begin
          pitch_nxt  = {store_r[3], store_r[2], store_r[1], store_r[0]};
          yaw_nxt    = {store_r[7], store_r[6], store_r[5], store_r[4]};
          status_nxt = ST_OK;
        end else begin
          tail_cnt_nxt = tail_cnt_r + CNT_W'(1);
          status_nxt   = ST_TAIL_ERR;
        end
        phase_nxt = PH_HEAD1;
      end
      default: begin
        // Waiting for the first header byte; an unused code behaves the same.
        phase_nxt = (rx_byte == HDR_A) ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD1;
      cmd_r      <= '0;
      len_r      <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
      pitch_r    <= '0;
      yaw_r      <= '0;
      cks_cnt_r  <= '0;
      tail_cnt_r <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (step) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      pitch_r    <= pitch_nxt;
      yaw_r      <= yaw_nxt;
      cks_cnt_r  <= cks_cnt_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      store_r    <= store_nxt;
    end
  end

  assign result.status               = status_nxt;
  assign result.frame_cmd            = cmd_r;
  assign result.pitch_word           = pitch_r;
  assign result.yaw_word             = yaw_r;
  assign result.checksum_error_count = cks_cnt_r;
  assign result.tail_error_count     = tail_cnt_r;

endmodule

// File: src/serial_frame_parser_checksum_core.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_checksum_core: byte-serial frame parser with checksum
// Hunts 0x55 0xAA / command / length / payload / checksum / 0x0D frames in a
// stream of received bytes and reports one result word per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_rx_byte) carries one received
//   serial byte per word. For every byte exactly one result word leaves on
//   the output channel: a status code (idle or in progress, frame accepted,
//   checksum error, tail error), the current command byte, the two
//   little-endian payload words of the last good frame and the two wrapping
//   error counters, all as they stand after that byte.
//   A byte is first captured in an input register; the parser steps on it
//   once the output slot is free, and the outcome is loaded into the output
//   register. A byte thus passes the input register and then the output
//   register before its result can be accepted, and a new byte is taken in
//   every cycle as long as the receiver keeps out_ready high.
//   When the receiver stalls, the pending result holds in the output
//   register and one more byte may still be captured in the input register;
//   after that in_ready drops until the result is taken.
//   The parser steps only when its result has a free slot, so the payload,
//   command and counter outputs come straight from the parser registers.
//   Synchronous reset returns the hunter to waiting for the first header
//   byte and clears the command, sums, payload store, words and counters.
// ----------------------------------------------------------------------------
module serial_frame_parser_checksum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_frame_cmd,
  output logic [31:0] out_pitch_word,
  output logic [31:0] out_yaw_word,
  output logic [31:0] out_checksum_error_count,
  output logic [31:0] out_tail_error_count
);
  import sfp_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  status_t     out_status_r;
  logic        advance;
  sfp_result_t result;

  // The parser steps on the held byte whenever the output slot is free or
  // is being emptied in this cycle.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_status_r <= result.status;
    end
  end

  sfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (result)
  );

  assign out_valid                = out_vld_r;
  assign out_status               = out_status_r;
  assign out_frame_cmd            = result.frame_cmd;
  assign out_pitch_word           = result.pitch_word;
  assign out_yaw_word             = result.yaw_word;
  assign out_checksum_error_count = result.checksum_error_count;
  assign out_tail_error_count     = result.tail_error_count;

  // A checksum failure reported for a byte bumps its counter by exactly one.
  a_cks_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(advance) && out_status_r == ST_CKSUM_ERR |->
      out_checksum_error_count == $past(out_checksum_error_count) + 32'd1)
    else $error("checksum error count did not advance with its status");

  // A tail failure reported for a byte bumps its counter by exactly one.
  a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(advance) && out_status_r == ST_TAIL_ERR |->
      out_tail_error_count == $past(out_tail_error_count) + 32'd1)
    else $error("tail error count did not advance with its status");

  // Both payload words change only with an accepted frame; this checks the pitch word.
  a_pitch_publish: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(out_pitch_word) |->
      $past(advance) && out_status_r == ST_OK)
    else $error("payload word changed without an accepted frame");

  // Without a step the parser's state, and so the counters, stay put.
  a_hold_counts: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |->
      $stable(out_checksum_error_count) && $stable(out_tail_error_count))
    else $error("error counters changed without a parser step");

endmodule
